// File: design/trsp_pkg.sv
package trsp_pkg;

  // Parser phases, one-hot.
  typedef enum logic [12:0] {
    PH_MAGIC = 13'b0_0000_0000_0001,
    PH_SKIP  = 13'b0_0000_0000_0010,
    PH_GTAG  = 13'b0_0000_0000_0100,
    PH_NLEN  = 13'b0_0000_0000_1000,
    PH_NAME  = 13'b0_0000_0001_0000,
    PH_LTAG  = 13'b0_0000_0010_0000,
    PH_COUNT = 13'b0_0000_0100_0000,
    PH_ESIZE = 13'b0_0000_1000_0000,
    PH_SLEN  = 13'b0_0001_0000_0000,
    PH_STXT  = 13'b0_0010_0000_0000,
    PH_TAIL  = 13'b0_0100_0000_0000,
    PH_DONE  = 13'b0_1000_0000_0000,
    PH_ERR   = 13'b1_0000_0000_0000
  } phase_t;

  typedef enum logic [2:0] {
    KIND_HEADER  = 3'd0,
    KIND_NAME    = 3'd1,
    KIND_ESIZE   = 3'd2,
    KIND_SLEN    = 3'd3,
    KIND_STXT    = 3'd4,
    KIND_TAIL    = 3'd5,
    KIND_STATUS  = 3'd6,
    KIND_IGNORED = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_MAGIC       = 3'd1,
    ERR_GAME        = 3'd2,
    ERR_LINE        = 3'd3,
    ERR_TRUNC_HDR   = 3'd4,
    ERR_TRUNC_ENTRY = 3'd5,
    ERR_OVERRUN     = 3'd6
  } err_t;

  // Tags stored little-endian: byte 0 of the tag is in bits 7:0.
  localparam logic [31:0] TAG_MAGIC = 32'h5F54_4545;  // "EET_"
  localparam logic [31:0] TAG_GAME  = 32'h454D_4147;  // "GAME"
  localparam logic [31:0] TAG_LINE  = 32'h454E_494C;  // "LINE"

  localparam logic [31:0] SKIP_BYTES   = 32'd8;
  localparam logic [3:0]  STATUS_POS   = 4'd8;
  localparam logic [3:0]  TAIL_POS_MAX = 4'd9;
  localparam logic [2:0]  LAST_SLOT    = 3'd5;

  typedef struct packed {
    logic       final_byte;
    logic       first_byte;
    logic [7:0] data_byte;
  } trsp_item_t;

  typedef struct packed {
    kind_t       byte_kind;
    logic [2:0]  string_slot;
    logic [7:0]  byte_value;
    logic [31:0] entry_number;
    logic        string_done;
    logic        entry_done;
    logic        all_done;
    err_t        error_code;
  } trsp_result_t;

  function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
    logic [7:0] sel;
    unique case (idx)
      2'd0: sel = tag[7:0];
      2'd1: sel = tag[15:8];
      2'd2: sel = tag[23:16];
      2'd3: sel = tag[31:24];
    endcase
    return sel;
  endfunction

endpackage

// File: design/tagged_record_stream_parser.sv
// Channel   | Direction | Signals                          | Contents
// ----------+-----------+----------------------------------+-----------------------------------
// s_axis    | in        | s_tvalid s_tready s_tdata        | file byte, restart flag (tuser),
//           |           | s_tuser s_tlast                  | last byte of file (tlast)
// m_axis    | out       | m_tvalid m_tready m_tdata        | one classification per file byte,
//           |           | m_tuser                          | byte kind in tuser
//
// One byte is accepted per clock cycle while m_tready stays high; the update of the
// parser phase and its counters is the loop that sets this rate.
// A byte is held in the input register and is parsed into the result register once
// that register is free, so its result is offered from the result register.
// rst is synchronous and active high; it returns the parser to the magic phase with
// all counters and the error code cleared, and empties both registers.
// When m_tready is low, the result register holds and the input register still takes
// one more byte, so the stream keeps moving up to the point where both are full.
module tagged_record_stream_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_tuser,   // [0] first_byte
  input  logic        s_tlast,   // final_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [2:0] string_slot, [10:3] byte_value,
                                 // [42:11] entry_number, [43] string_done,
                                 // [44] entry_done, [45] all_done,
                                 // [48:46] error_code, [55:49] zero
  output logic [2:0]  m_tuser    // [2:0] byte_kind
);
  import trsp_pkg::*;

  trsp_item_t   in_item;
  trsp_item_t   held_item;
  logic         held_valid;
  logic         out_free;
  logic         advance;
  trsp_result_t core_result;
  trsp_result_t out_result;

  assign in_item.data_byte  = s_tdata;
  assign in_item.first_byte = s_tuser[0];
  assign in_item.final_byte = s_tlast;

  // A held byte is parsed in the cycle it moves into the result register; the parser
  // state advances only then, so stalls never repeat or drop a byte.
  assign advance = held_valid && out_free;

  trsp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .held_valid (held_valid),
    .held_item  (held_item),
    .advance    (advance)
  );

  trsp_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (held_item),
    .result (core_result)
  );

  trsp_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .load        (advance),
    .free        (out_free),
    .load_result (core_result),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_result  (out_result)
  );

  // Result fields packed from the lowest bit up, padded to whole bytes.
  assign m_tdata = {7'd0,
                    out_result.error_code,
                    out_result.all_done,
                    out_result.entry_done,
                    out_result.string_done,
                    out_result.entry_number,
                    out_result.byte_value,
                    out_result.string_slot};
  assign m_tuser = out_result.byte_kind;

endmodule

// File: design/trsp_in_reg.sv
module trsp_in_reg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  trsp_pkg::trsp_item_t   in_item,
  output logic                   held_valid,
  output trsp_pkg::trsp_item_t   held_item,
  input  logic                   advance
);
  import trsp_pkg::*;

  // The register may refill in the same cycle that its item moves on.
  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

// File: design/trsp_core.sv
module trsp_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  trsp_pkg::trsp_item_t   item,
  output trsp_pkg::trsp_result_t result
);
  import trsp_pkg::*;

  phase_t      phase, phase_next, cur_phase;
  logic [31:0] field_counter, field_counter_next, cur_fc;
  logic [31:0] value_shift, value_shift_next, cur_vs;
  logic [31:0] entry_bytes_left, entry_bytes_left_next, cur_ebl;
  logic [31:0] entries_left, entries_left_next, cur_el;
  logic [31:0] entry_index, entry_index_next, cur_ei;
  logic [2:0]  slot, slot_next, cur_slot;
  logic [3:0]  tail_position, tail_position_next, cur_tp;
  err_t        sticky_error, sticky_error_next, cur_err;

  logic [1:0]  idx;
  logic [7:0]  b;
  logic [31:0] merged, fc_inc, fc_dec, ebl_dec, el_dec;
  logic        string_end, entry_close;
  kind_t       kind;
  logic [2:0]  oslot;
  logic        sdone, edone, adone;

  always_comb begin
    // A first byte restarts the parser before the byte is classified.
    if (item.first_byte) begin
      cur_phase = PH_MAGIC;
      cur_fc    = '0;
      cur_vs    = '0;
      cur_ebl   = '0;
      cur_el    = '0;
      cur_ei    = '0;
      cur_slot  = '0;
      cur_tp    = '0;
      cur_err   = ERR_NONE;
    end else begin
      cur_phase = phase;
      cur_fc    = field_counter;
      cur_vs    = value_shift;
      cur_ebl   = entry_bytes_left;
      cur_el    = entries_left;
      cur_ei    = entry_index;
      cur_slot  = slot;
      cur_tp    = tail_position;
      cur_err   = sticky_error;
    end

    phase_next            = cur_phase;
    field_counter_next    = cur_fc;
    value_shift_next      = cur_vs;
    entry_bytes_left_next = cur_ebl;
    entries_left_next     = cur_el;
    entry_index_next      = cur_ei;
    slot_next             = cur_slot;
    tail_position_next    = cur_tp;
    sticky_error_next     = cur_err;

    b       = item.data_byte;
    idx     = cur_fc[1:0];
    merged  = cur_vs | ({24'd0, b} << {idx, 3'b000});
    fc_inc  = cur_fc + 32'd1;
    fc_dec  = cur_fc - 32'd1;
    ebl_dec = cur_ebl - 32'd1;
    el_dec  = cur_el - 32'd1;

    kind        = KIND_IGNORED;
    oslot       = '0;
    sdone       = 1'b0;
    edone       = 1'b0;
    adone       = 1'b0;
    string_end  = 1'b0;
    entry_close = 1'b0;

    unique case (cur_phase)
      PH_MAGIC: begin
        kind = KIND_HEADER;
        if (b != tag_byte(TAG_MAGIC, idx)) begin
          phase_next        = PH_ERR;
          sticky_error_next = ERR_MAGIC;
        end else if (idx == 2'd3) begin
          phase_next         = PH_SKIP;
          field_counter_next = '0;
          value_shift_next   = '0;
        end else begin
          field_counter_next = fc_inc;
          value_shift_next   = merged;
        end
      end
      PH_SKIP: begin
        kind               = KIND_HEADER;
        field_counter_next = fc_inc;
        if (fc_inc >= SKIP_BYTES) begin
          phase_next         = PH_GTAG;
          field_counter_next = '0;
          value_shift_next   = '0;
        end
      end
      PH_GTAG: begin
        kind = KIND_HEADER;
        if (b != tag_byte(TAG_GAME, idx)) begin
          phase_next        = PH_ERR;
          sticky_error_next = ERR_GAME;
        end else if (idx == 2'd3) begin
          phase_next         = PH_NLEN;
          field_counter_next = '0;
          value_shift_next   = '0;
        end else begin
          field_counter_next = fc_inc;
          value_shift_next   = merged;
        end
      end
      PH_NLEN: begin
        kind = KIND_HEADER;
        if (idx == 2'd1) begin
          value_shift_next = '0;
          if (merged == '0) begin
            phase_next         = PH_LTAG;
            field_counter_next = '0;
          end else begin
            phase_next         = PH_NAME;
            field_counter_next = merged;
          end
        end else begin
          field_counter_next = fc_inc;
          value_shift_next   = merged;
        end
      end
      PH_NAME: begin
        kind               = KIND_NAME;
        field_counter_next = fc_dec;
        if (fc_dec == '0) begin
          phase_next       = PH_LTAG;
          value_shift_next = '0;
        end
      end
      PH_LTAG: begin
        kind = KIND_HEADER;
        if (b != tag_byte(TAG_LINE, idx)) begin
          phase_next        = PH_ERR;
          sticky_error_next = ERR_LINE;
        end else if (idx == 2'd3) begin
          phase_next         = PH_COUNT;
          field_counter_next = '0;
          value_shift_next   = '0;
        end else begin
          field_counter_next = fc_inc;
          value_shift_next   = merged;
        end
      end
      PH_COUNT: begin
        kind = KIND_HEADER;
        if (idx == 2'd3) begin
          entries_left_next = merged;
          entry_index_next  = '0;
          if (merged == '0) begin
            phase_next = PH_DONE;
            adone      = 1'b1;
          end else begin
            phase_next         = PH_ESIZE;
            field_counter_next = '0;
            value_shift_next   = '0;
          end
        end else begin
          field_counter_next = fc_inc;
          value_shift_next   = merged;
        end
      end
      PH_ESIZE: begin
        kind = KIND_ESIZE;
        if (idx == 2'd3) begin
          entry_bytes_left_next = merged;
          slot_next             = '0;
          phase_next            = PH_SLEN;
          field_counter_next    = '0;
          value_shift_next      = '0;
        end else begin
          field_counter_next = fc_inc;
          value_shift_next   = merged;
        end
      end
      PH_SLEN: begin
        kind  = KIND_SLEN;
        oslot = cur_slot;
        if (cur_ebl == '0) begin
          phase_next        = PH_ERR;
          sticky_error_next = ERR_OVERRUN;
        end else begin
          entry_bytes_left_next = ebl_dec;
          if (idx == 2'd3) begin
            // A string longer than what is left of the entry is an overrun.
            if (merged > ebl_dec) begin
              phase_next        = PH_ERR;
              sticky_error_next = ERR_OVERRUN;
            end else if (merged == '0) begin
              string_end = 1'b1;
            end else begin
              phase_next         = PH_STXT;
              field_counter_next = merged;
              value_shift_next   = merged;
            end
          end else begin
            field_counter_next = fc_inc;
            value_shift_next   = merged;
          end
        end
      end
      PH_STXT: begin
        kind  = KIND_STXT;
        oslot = cur_slot;
        if (cur_ebl == '0 || cur_fc == '0) begin
          phase_next        = PH_ERR;
          sticky_error_next = ERR_OVERRUN;
        end else begin
          entry_bytes_left_next = ebl_dec;
          field_counter_next    = fc_dec;
          if (fc_dec == '0) begin
            string_end = 1'b1;
          end
        end
      end
      PH_TAIL: begin
        kind = (cur_tp == STATUS_POS) ? KIND_STATUS : KIND_TAIL;
        if (cur_tp < TAIL_POS_MAX) begin
          tail_position_next = cur_tp + 4'd1;
        end
        if (cur_ebl != '0) begin
          entry_bytes_left_next = ebl_dec;
        end
        if (cur_ebl == '0 || ebl_dec == '0) begin
          entry_close = 1'b1;
        end
      end
      PH_DONE: begin
        adone = 1'b1;
      end
      PH_ERR: begin
        phase_next = PH_ERR;
      end
      default: begin
        phase_next = PH_ERR;
      end
    endcase

    if (string_end) begin
      sdone = 1'b1;
      if (cur_slot >= LAST_SLOT) begin
        slot_next = '0;
        if (entry_bytes_left_next == '0) begin
          entry_close = 1'b1;
        end else begin
          phase_next         = PH_TAIL;
          tail_position_next = '0;
        end
      end else begin
        slot_next          = cur_slot + 3'd1;
        phase_next         = PH_SLEN;
        field_counter_next = '0;
        value_shift_next   = '0;
      end
    end

    if (entry_close) begin
      edone             = 1'b1;
      entries_left_next = el_dec;
      entry_index_next  = cur_ei + 32'd1;
      if (el_dec == '0) begin
        phase_next = PH_DONE;
        adone      = 1'b1;
      end else begin
        phase_next         = PH_ESIZE;
        field_counter_next = '0;
        value_shift_next   = '0;
      end
    end

    // The file ended before the parse completed.
    if (item.final_byte && phase_next != PH_DONE && phase_next != PH_ERR) begin
      if (phase_next == PH_MAGIC || phase_next == PH_SKIP || phase_next == PH_GTAG ||
          phase_next == PH_NLEN || phase_next == PH_NAME || phase_next == PH_LTAG ||
          phase_next == PH_COUNT) begin
        sticky_error_next = ERR_TRUNC_HDR;
      end else begin
        sticky_error_next = ERR_TRUNC_ENTRY;
      end
      phase_next = PH_ERR;
    end

    result.byte_kind    = kind;
    result.string_slot  = oslot;
    result.byte_value   = b;
    result.entry_number = cur_ei;
    result.string_done  = sdone;
    result.entry_done   = edone;
    result.all_done     = adone;
    result.error_code   = sticky_error_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_MAGIC;
      field_counter    <= '0;
      value_shift      <= '0;
      entry_bytes_left <= '0;
      entries_left     <= '0;
      entry_index      <= '0;
      slot             <= '0;
      tail_position    <= '0;
      sticky_error     <= ERR_NONE;
    end else if (fire) begin
      phase            <= phase_next;
      field_counter    <= field_counter_next;
      value_shift      <= value_shift_next;
      entry_bytes_left <= entry_bytes_left_next;
      entries_left     <= entries_left_next;
      entry_index      <= entry_index_next;
      slot             <= slot_next;
      tail_position    <= tail_position_next;
      sticky_error     <= sticky_error_next;
    end
  end

`ifndef SYNTH
  // Once raised, an error stays until a new file starts.
  assert property (@(posedge clk) disable iff (rst)
    (fire && !item.first_byte && sticky_error != ERR_NONE) |=>
      (sticky_error == $past(sticky_error)))
    else $error("sticky error changed without a restart");

  assert property (@(posedge clk) disable iff (rst)
    (fire && result.string_done) |->
      (result.byte_kind == KIND_SLEN || result.byte_kind == KIND_STXT))
    else $error("string completion on a byte outside a string");

  // Completion is raised either by the last entry or by an empty count.
  assert property (@(posedge clk) disable iff (rst)
    (fire && result.all_done && result.byte_kind != KIND_IGNORED) |->
      (result.entry_done || result.byte_kind == KIND_HEADER))
    else $error("completion without a finished entry or empty count");

  assert property (@(posedge clk) disable iff (rst)
    slot <= LAST_SLOT)
    else $error("string slot out of range");
`endif

endmodule

// File: design/trsp_out_reg.sv
module trsp_out_reg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  output logic                   free,
  input  trsp_pkg::trsp_result_t load_result,
  output logic                   out_valid,
  input  logic                   out_ready,
  output trsp_pkg::trsp_result_t out_result
);
  import trsp_pkg::*;

  // A result that is being taken frees the register for the next one.
  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_result <= load_result;
    end
  end

endmodule
